[rtl/lum_pkg.sv]
// Shared types, constants and fixed-point helpers of the lens undistortion map.
`default_nettype none
package lum_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    CFG_FOCAL_X    = 3'd0,
    CFG_FOCAL_Y    = 3'd1,
    CFG_CENTER_X   = 3'd2,
    CFG_CENTER_Y   = 3'd3,
    CFG_RADIAL_K1  = 3'd4,
    CFG_RADIAL_K2  = 3'd5,
    CFG_RADIAL_K3  = 3'd6,
    CFG_TANGENTIAL = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
  } req_t;

  typedef struct packed {
    logic signed [31:0] source_x;
    logic signed [31:0] source_y;
  } result_t;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 64;
  localparam int unsigned QFrac       = 28;
  localparam logic signed [31:0] QOne = 32'sh1000_0000;
  localparam logic signed [31:0] SMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] SMin = 32'sh8000_0000;

  // Cycles through the divider and through the whole block.
  localparam int unsigned DivLatency = 35;
  localparam int unsigned LumLatency = 55;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
    logic signed [31:0] r;
    if (x > 40'sh00_7fff_ffff) begin
      r = SMax;
    end else if (x < -40'sh00_8000_0000) begin
      r = SMin;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Q4.28 product back to Q4.28: round to nearest, ties away from zero, saturate.
  function automatic logic signed [31:0] mul_round(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [63:0] q;
    logic signed [31:0] r;
    mag = p[63] ? 64'(-p) : 64'(p);
    q   = (mag + (64'd1 << (QFrac - 1))) >> QFrac;
    if (!p[63]) begin
      r = (q > 64'h7fff_ffff) ? SMax : $signed(q[31:0]);
    end else begin
      r = (q > 64'h8000_0000) ? SMin : $signed(-q[31:0]);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/lum_div.sv]
// Pipelined restoring divider: offset pixel over focal length into saturated Q4.28.
`default_nettype none
module lum_div
  import lum_pkg::*;
(
  input  logic               clk_i,
  input  logic signed [33:0] num_i,
  input  logic [31:0]        den_i,
  output logic signed [31:0] quo_o
);

  logic [31:0] den;
  logic        neg0_q;
  logic [60:0] n0_q;
  logic [33:0] mag;
  logic [60:0] n0_d;

  logic [31:0] r_q   [0:32];
  logic [31:0] lo_q  [0:32];
  logic [31:0] q_q   [0:32];
  logic        neg_q [0:32];
  logic        ovf_q [0:32];
  logic signed [31:0] quo_q;
  logic signed [31:0] quo_d;

  // A focal length of zero divides as one raw unit.
  assign den = (den_i == 32'd0) ? 32'd1 : den_i;

  assign mag  = num_i[33] ? 34'(-num_i) : 34'(num_i);
  assign n0_d = {1'b0, mag[31:0], 28'd0} + 61'(den >> 1);

  always_ff @(posedge clk_i) begin
    neg0_q   <= num_i[33];
    n0_q     <= n0_d;
    r_q[0]   <= {3'd0, n0_q[60:32]};
    lo_q[0]  <= n0_q[31:0];
    q_q[0]   <= 32'd0;
    neg_q[0] <= neg0_q;
    // A quotient of 2^32 or more saturates whatever its low bits are.
    ovf_q[0] <= ({3'd0, n0_q[60:32]} >= den);
  end

  for (genvar i = 0; i < 32; i++) begin : g_step
    logic [32:0] rt;
    logic [33:0] diff;
    logic        ge;
    assign rt   = {r_q[i], lo_q[i][31]};
    assign diff = {1'b0, rt} - {2'd0, den};
    assign ge   = !diff[33];
    always_ff @(posedge clk_i) begin
      r_q[i+1]   <= ge ? diff[31:0] : rt[31:0];
      lo_q[i+1]  <= {lo_q[i][30:0], 1'b0};
      q_q[i+1]   <= {q_q[i][30:0], ge};
      neg_q[i+1] <= neg_q[i];
      ovf_q[i+1] <= ovf_q[i];
    end
  end

  always_comb begin
    if (ovf_q[32]) begin
      quo_d = neg_q[32] ? SMin : SMax;
    end else if (!neg_q[32]) begin
      quo_d = q_q[32][31] ? SMax : $signed(q_q[32]);
    end else begin
      quo_d = (q_q[32] > 32'h8000_0000) ? SMin : $signed(-q_q[32]);
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule
`default_nettype wire

[rtl/lens_undistortion_map.sv]
// Top level of the Brown-Conrady lens undistortion map.
// One request (column, row) is taken in every clock cycle in which start is
// high; its source coordinate then appears on result_o with result_valid_o;
// busy stays low, and results cannot be held off. Most of the pipeline is the
// pair of pipelined dividers that normalize by the focal lengths, one stage per
// quotient bit; much of the rest is the polynomial, one multiplier stage, one
// rounding stage and one add stage per step. Registers are to be written by the
// user only while no request is in flight; the block does not enforce it itself.
`default_nettype none
module lens_undistortion_map
  import lum_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  req_t                   req_i,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i,
  output logic                   result_valid_o,
  output result_t                result_o
);

  localparam logic [15:0] CoordMask = 16'((32'd1 << COORD_BITS) - 32'd1);

  logic [31:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic signed [31:0] k1_q, k2_q, k3_q;
  logic [63:0] tangential_q;
  logic signed [31:0] p1, p2;

  logic [LumLatency-1:0] vld_q, vld_d;

  assign busy = 1'b0;
  assign p1   = $signed(tangential_q[63:32]);
  assign p2   = $signed(tangential_q[31:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q    <= 32'h0001_0000;
      focal_y_q    <= 32'h0001_0000;
      center_x_q   <= 32'd0;
      center_y_q   <= 32'd0;
      k1_q         <= 32'sd0;
      k2_q         <= 32'sd0;
      k3_q         <= 32'sd0;
      tangential_q <= 64'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FOCAL_X:    focal_x_q    <= cfg_wdata_i[31:0];
        CFG_FOCAL_Y:    focal_y_q    <= cfg_wdata_i[31:0];
        CFG_CENTER_X:   center_x_q   <= cfg_wdata_i[31:0];
        CFG_CENTER_Y:   center_y_q   <= cfg_wdata_i[31:0];
        CFG_RADIAL_K1:  k1_q         <= $signed(cfg_wdata_i[31:0]);
        CFG_RADIAL_K2:  k2_q         <= $signed(cfg_wdata_i[31:0]);
        CFG_RADIAL_K3:  k3_q         <= $signed(cfg_wdata_i[31:0]);
        CFG_TANGENTIAL: tangential_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign vld_d = {vld_q[LumLatency-2:0], start && !busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Capture and offset by the principal point.
  logic [15:0] u_q, v_q;
  logic signed [33:0] ox_q, oy_q;

  always_ff @(posedge clk_i) begin
    u_q  <= 16'(req_i.column) & CoordMask;
    v_q  <= 16'(req_i.row) & CoordMask;
    ox_q <= $signed({2'd0, u_q, 16'd0}) - $signed({2'd0, center_x_q});
    oy_q <= $signed({2'd0, v_q, 16'd0}) - $signed({2'd0, center_y_q});
  end

  logic signed [31:0] nx, ny;

  lum_div u_div_x (.clk_i(clk_i), .num_i(ox_q), .den_i(focal_x_q), .quo_o(nx));
  lum_div u_div_y (.clk_i(clk_i), .num_i(oy_q), .den_i(focal_y_q), .quo_o(ny));

  // Delay lines for operands that skip stages.
  logic signed [31:0] nxd_q [0:11];
  logic signed [31:0] nyd_q [0:11];
  logic signed [31:0] r2d_q [0:6];
  logic signed [31:0] xyd_q [0:2];
  logic signed [33:0] tanxd_q [0:7];
  logic signed [33:0] tanyd_q [0:7];

  logic signed [63:0] pxx_q, pyy_q, pxy_q;
  logic signed [31:0] xx_q, yy_q;
  logic signed [31:0] xx2_q, yy2_q, ax_q, ay_q;
  logic signed [63:0] pk4_q, pk7_q, pk10_q;
  logic signed [31:0] t5_q, t8_q, t11_q;
  logic signed [31:0] s6_q, s9_q, s12_q;
  logic signed [63:0] pt1_q, pt2_q, pt3_q, pt4_q;
  logic signed [31:0] tt1_q, tt2_q, tt3_q, tt4_q;
  logic signed [63:0] pdx_q, pdy_q;
  logic signed [31:0] mdx_q, mdy_q;
  logic signed [31:0] dx_q, dy_q;
  logic signed [64:0] pfx_q, pfy_q;
  logic signed [36:0] rx_q, ry_q, rx_d, ry_d;
  result_t res_q, res_d;

  // Fixed-point round of the focal scaling, not saturated yet.
  function automatic logic signed [36:0] scale_round(input logic signed [64:0] p);
    logic [63:0] mag;
    logic [35:0] q;
    logic signed [36:0] r;
    mag = p[64] ? 64'(-p) : 64'(p);
    q   = 36'((mag + (64'd1 << (QFrac - 1))) >> QFrac);
    r   = p[64] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    return r;
  endfunction

  assign rx_d = scale_round(pfx_q);
  assign ry_d = scale_round(pfy_q);

  always_comb begin
    res_d.source_x = sat32(40'(rx_q) + 40'($signed({1'b0, center_x_q})));
    res_d.source_y = sat32(40'(ry_q) + 40'($signed({1'b0, center_y_q})));
  end

  always_ff @(posedge clk_i) begin
    nxd_q[0] <= nx;
    nyd_q[0] <= ny;
    for (int i = 1; i < 12; i++) begin
      nxd_q[i] <= nxd_q[i-1];
      nyd_q[i] <= nyd_q[i-1];
    end
    for (int i = 1; i < 7; i++) begin
      r2d_q[i] <= r2d_q[i-1];
    end
    for (int i = 1; i < 3; i++) begin
      xyd_q[i] <= xyd_q[i-1];
    end
    for (int i = 1; i < 8; i++) begin
      tanxd_q[i] <= tanxd_q[i-1];
      tanyd_q[i] <= tanyd_q[i-1];
    end

    // Squares and cross product.
    pxx_q <= nx * nx;
    pyy_q <= ny * ny;
    pxy_q <= nx * ny;
    xx_q  <= mul_round(pxx_q);
    yy_q  <= mul_round(pyy_q);
    xyd_q[0] <= mul_round(pxy_q);
    r2d_q[0] <= sat32(40'(xx_q) + 40'(yy_q));
    xx2_q <= sat32(40'(xx_q) + 40'(xx_q));
    yy2_q <= sat32(40'(yy_q) + 40'(yy_q));

    // Radial polynomial, innermost coefficient first.
    pk4_q <= r2d_q[0] * k3_q;
    ax_q  <= sat32(40'(r2d_q[0]) + 40'(xx2_q));
    ay_q  <= sat32(40'(r2d_q[0]) + 40'(yy2_q));
    t5_q  <= mul_round(pk4_q);
    s6_q  <= sat32(40'(k2_q) + 40'(t5_q));
    pk7_q <= r2d_q[3] * s6_q;
    t8_q  <= mul_round(pk7_q);
    s9_q  <= sat32(40'(k1_q) + 40'(t8_q));
    pk10_q <= r2d_q[6] * s9_q;
    t11_q <= mul_round(pk10_q);
    s12_q <= sat32(40'(QOne) + 40'(t11_q));

    // Tangential terms run beside the polynomial.
    pt1_q <= p1 * xyd_q[2];
    pt2_q <= p2 * ax_q;
    pt3_q <= p1 * ay_q;
    pt4_q <= p2 * xyd_q[2];
    tt1_q <= mul_round(pt1_q);
    tt2_q <= mul_round(pt2_q);
    tt3_q <= mul_round(pt3_q);
    tt4_q <= mul_round(pt4_q);
    tanxd_q[0] <= 34'(sat32(40'(tt1_q) + 40'(tt1_q))) + 34'(tt2_q);
    tanyd_q[0] <= 34'(tt3_q) + 34'(sat32(40'(tt4_q) + 40'(tt4_q)));

    // Distorted point and scaling back to pixels.
    pdx_q <= nxd_q[11] * s12_q;
    pdy_q <= nyd_q[11] * s12_q;
    mdx_q <= mul_round(pdx_q);
    mdy_q <= mul_round(pdy_q);
    dx_q  <= sat32(40'(mdx_q) + 40'(tanxd_q[7]));
    dy_q  <= sat32(40'(mdy_q) + 40'(tanyd_q[7]));
    pfx_q <= dx_q * $signed({1'b0, focal_x_q});
    pfy_q <= dy_q * $signed({1'b0, focal_y_q});
    rx_q  <= rx_d;
    ry_q  <= ry_d;
    res_q <= res_d;
  end

  assign result_valid_o = vld_q[LumLatency-1];
  assign result_o       = res_q;

endmodule
`default_nettype wire

[rtl/lum_assert.sv]
// Port-level checks of the lens undistortion map and their bind to the top level.
`default_nettype none
module lum_assert
  import lum_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o
);

  // The block never holds off a request.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // Every accepted request yields its result after the fixed latency.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LumLatency result_valid_o)
    else $error("result missing after request");

  // No result appears without a request at the matching cycle.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LumLatency))
    else $error("result without request");

endmodule

bind lens_undistortion_map lum_assert u_lum_assert (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .start(start),
  .busy(busy),
  .result_valid_o(result_valid_o)
);
`default_nettype wire

[verif/tb_lens_undistortion_map.sv]
// Self-checking testbench of the lens undistortion map: directed table, then random pixels.
`timescale 1ns / 100ps
module tb_lens_undistortion_map;
  import lum_pkg::*;

  localparam int unsigned HoldCycles = LumLatency + 10;
  localparam int unsigned WatchLimit = 400;

  typedef struct {
    logic [11:0] column;
    logic [11:0] row;
    logic        has_exp;
    logic [31:0] exp_x;
    logic [31:0] exp_y;
  } pix_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [CfgDataBits-1:0] cfg_wdata_i = '0;
  logic result_valid_o;
  result_t result_o;

  // Local copy of the register file used by the predictor.
  logic [31:0] fx_q, fy_q, cx_q, cy_q, k1_q, k2_q, k3_q;
  logic [63:0] tan_q;

  result_t pending_src[$];
  int unsigned n_err = 0;
  int unsigned idle_cycles = 0;
  logic quiet_phase = 1'b0;

  lens_undistortion_map uut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic neg;
    logic [63:0] m;
    neg = (a < 0) != (b < 0);
    m = 64'(a < 0 ? -a : a) * 64'(b < 0 ? -b : b);
    m = (m + (64'd1 << 27)) >> 28;
    return clip32(neg ? -longint'(m) : longint'(m));
  endfunction

  function automatic longint norm_coord(logic [11:0] pix, logic [31:0] ctr, logic [31:0] foc);
    longint d;
    logic [63:0] f, m, q;
    d = (longint'(pix) <<< 16) - longint'(ctr);
    f = (foc == 0) ? 64'd1 : 64'(foc);
    m = 64'(d < 0 ? -d : d) << 28;
    q = (m + f / 2) / f;
    return clip32(d < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic logic [31:0] denorm_coord(longint n, logic [31:0] foc, logic [31:0] ctr);
    logic [63:0] m;
    longint p;
    m = 64'(n < 0 ? -n : n) * 64'(foc);
    m = (m + (64'd1 << 27)) >> 28;
    p = n < 0 ? -longint'(m) : longint'(m);
    return 32'(clip32(p + longint'(ctr)));
  endfunction

  function automatic result_t predict_source(logic [11:0] col, logic [11:0] rw);
    longint k1, k2, k3, p1, p2, nx, ny, xx, yy, xy, r2, s, dx, dy;
    result_t r;
    k1 = longint'($signed(k1_q));
    k2 = longint'($signed(k2_q));
    k3 = longint'($signed(k3_q));
    p1 = longint'($signed(tan_q[63:32]));
    p2 = longint'($signed(tan_q[31:0]));
    nx = norm_coord(col, cx_q, fx_q);
    ny = norm_coord(rw, cy_q, fy_q);
    xx = qmul(nx, nx);
    yy = qmul(ny, ny);
    xy = qmul(nx, ny);
    r2 = clip32(xx + yy);
    s = clip32(k2 + qmul(r2, k3));
    s = clip32(k1 + qmul(r2, s));
    s = clip32(64'sd268435456 + qmul(r2, s));
    dx = clip32(qmul(nx, s) + clip32(2 * qmul(p1, xy)) + qmul(p2, clip32(r2 + clip32(2 * xx))));
    dy = clip32(qmul(ny, s) + qmul(p1, clip32(r2 + clip32(2 * yy))) + clip32(2 * qmul(p2, xy)));
    r.source_x = denorm_coord(dx, fx_q, cx_q);
    r.source_y = denorm_coord(dy, fy_q, cy_q);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    n_err++;
  endtask

  // Results are sampled at the rising edge and compared with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_src.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        result_t e;
        e = pending_src.pop_front();
        if (result_o.source_x !== e.source_x)
          report_mismatch($sformatf("source_x got %h want %h", result_o.source_x, e.source_x));
        if (result_o.source_y !== e.source_y)
          report_mismatch($sformatf("source_y got %h want %h", result_o.source_y, e.source_y));
      end
    end
  end

  // Watchdog: counts cycles with neither a request nor a result accepted.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchLimit) begin
      $display("tb_lens_undistortion_map: done, errors");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_FOCAL_X: fx_q = val[31:0];
      CFG_FOCAL_Y: fy_q = val[31:0];
      CFG_CENTER_X: cx_q = val[31:0];
      CFG_CENTER_Y: cy_q = val[31:0];
      CFG_RADIAL_K1: k1_q = val[31:0];
      CFG_RADIAL_K2: k2_q = val[31:0];
      CFG_RADIAL_K3: k3_q = val[31:0];
      default: tan_q = val;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain_pipe();
    int unsigned n;
    n = 0;
    while (pending_src.size() != 0 && n < 4 * HoldCycles) begin
      @(negedge clk_i);
      n++;
    end
    repeat (HoldCycles) @(negedge clk_i);
  endtask

  // Offers one request; start is held across back-to-back requests without toggling.
  task automatic send_pixel(logic [11:0] col, logic [11:0] rw);
    int unsigned gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{column: col, row: rw};
    do @(posedge clk_i); while (busy);
    pending_src.push_back(predict_source(col, rw));
    @(negedge clk_i);
  endtask

  task automatic random_config(int unsigned flavor);
    case (flavor)
      0: begin
        write_reg(CFG_FOCAL_X, 64'($urandom_range(200, 3000)) << 16);
        write_reg(CFG_FOCAL_Y, 64'($urandom_range(200, 3000)) << 16);
        write_reg(CFG_CENTER_X, 64'($urandom_range(0, 4095)) << 16 | $urandom_range(0, 65535));
        write_reg(CFG_CENTER_Y, 64'($urandom_range(0, 4095)) << 16 | $urandom_range(0, 65535));
        write_reg(CFG_RADIAL_K1, 64'($signed(32'($urandom)) >>> 4));
        write_reg(CFG_RADIAL_K2, 64'($signed(32'($urandom)) >>> 6));
        write_reg(CFG_RADIAL_K3, 64'($signed(32'($urandom)) >>> 8));
        write_reg(CFG_TANGENTIAL, {32'($signed(32'($urandom)) >>> 9),
                                   32'($signed(32'($urandom)) >>> 9)});
      end
      default: begin
        // Full-range registers, including zero focal lengths and extreme coefficients.
        write_reg(CFG_FOCAL_X, ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom));
        write_reg(CFG_FOCAL_Y, ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom));
        write_reg(CFG_CENTER_X, 64'($urandom));
        write_reg(CFG_CENTER_Y, 64'($urandom));
        write_reg(CFG_RADIAL_K1, 64'($urandom));
        write_reg(CFG_RADIAL_K2, 64'($urandom));
        write_reg(CFG_RADIAL_K3, 64'($urandom));
        write_reg(CFG_TANGENTIAL, {32'($urandom), 32'($urandom)});
      end
    endcase
  endtask

  pix_row_t pix_table[] = '{
    '{12'd0, 12'd0, 1'b1, 32'h0000_0000, 32'h0000_0000},
    '{12'd1, 12'd0, 1'b1, 32'h0001_0000, 32'h0000_0000},
    '{12'd0, 12'd1, 1'b1, 32'h0000_0000, 32'h0001_0000},
    '{12'd5, 12'd3, 1'b1, 32'h0005_0000, 32'h0003_0000},
    '{12'd4095, 12'd4095, 1'b0, 32'h0, 32'h0},
    '{12'd4095, 12'd0, 1'b0, 32'h0, 32'h0},
    '{12'd0, 12'd4095, 1'b0, 32'h0, 32'h0},
    '{12'd2048, 12'd2047, 1'b0, 32'h0, 32'h0},
    '{12'd1234, 12'd321, 1'b0, 32'h0, 32'h0},
    '{12'd7, 12'd8, 1'b0, 32'h0, 32'h0}
  };

  initial begin
    int unsigned phase;
    logic [11:0] col, rw;
    fx_q = 32'h0001_0000;
    fy_q = 32'h0001_0000;
    cx_q = '0; cy_q = '0; k1_q = '0; k2_q = '0; k3_q = '0; tan_q = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // After reset the map is the identity for small coordinates.
    foreach (pix_table[i]) begin
      send_pixel(pix_table[i].column, pix_table[i].row);
      if (pix_table[i].has_exp) begin
        pending_src[$].source_x = pix_table[i].exp_x;
        pending_src[$].source_y = pix_table[i].exp_y;
      end
    end
    start <= 1'b0;
    drain_pipe();

    // Extreme registers: zero and maximal focal lengths, zero and maximal centers, extreme coefficients.
    write_reg(CFG_FOCAL_X, 64'd0);
    write_reg(CFG_FOCAL_Y, 64'hFFFF_FFFF);
    write_reg(CFG_CENTER_X, 64'hFFFF_FFFF);
    write_reg(CFG_CENTER_Y, 64'd0);
    write_reg(CFG_RADIAL_K1, 64'h7FFF_FFFF);
    write_reg(CFG_RADIAL_K2, 64'h8000_0000);
    write_reg(CFG_RADIAL_K3, 64'h7FFF_FFFF);
    write_reg(CFG_TANGENTIAL, 64'h8000_0000_7FFF_FFFF);
    foreach (pix_table[i]) send_pixel(pix_table[i].column, pix_table[i].row);
    start <= 1'b0;
    drain_pipe();

    for (phase = 0; phase < 12; phase++) begin
      random_config(phase % 3 == 2 ? 1 : 0);
      if (phase >= 10) quiet_phase = 1'b1;
      repeat (100) begin
        col = 12'($urandom);
        rw = 12'($urandom);
        send_pixel(col, rw);
      end
      start <= 1'b0;
      drain_pipe();
    end

    if (n_err == 0 && pending_src.size() == 0) begin
      $display("tb_lens_undistortion_map: done, clean");
    end else begin
      $display("tb_lens_undistortion_map: done, errors");
    end
    $finish;
  end
endmodule

[files.f]
rtl/lum_pkg.sv
rtl/lum_div.sv
rtl/lens_undistortion_map.sv
rtl/lum_assert.sv
verif/tb_lens_undistortion_map.sv
